/* design/alps_pkg.sv */
// shared types and constants for the averaged level pulse-count sender
`timescale 1ns / 1ps

package alps_pkg;

  // samples that form one average
  localparam int unsigned SamplesAveraged = 3;

  // divide by three as multiply by reciprocal then shift, exact for 10-bit sums
  localparam int unsigned RecipShift = 11;
  localparam logic [9:0]  RecipMul   = 10'd683;

  // widths of state and configuration values
  localparam int unsigned SumW   = 10;
  localparam int unsigned AvgW   = 9;
  localparam int unsigned LevelW = 8;
  localparam int unsigned TicksW = 16;
  localparam int unsigned CountW = 2;

  // configuration port
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 16;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] RegMaxLevel   = 2'd0;
  localparam logic [CfgIndexW-1:0] RegTriggerLow = 2'd1;
  localparam logic [CfgIndexW-1:0] RegHalfBit    = 2'd2;
  localparam logic [CfgIndexW-1:0] RegBlinkPer   = 2'd3;

  // configuration reset values
  localparam logic [LevelW-1:0] MaxLevelRst   = 8'd237;
  localparam logic [TicksW-1:0] TriggerLowRst = 16'd256;
  localparam logic [TicksW-1:0] HalfBitRst    = 16'd128;
  localparam logic [TicksW-1:0] BlinkPerRst   = 16'd16384;

  // input item codes
  localparam logic ModeSample = 1'b0;
  localparam logic ModeTick   = 1'b1;

  // transmit phase, one-hot
  typedef enum logic [4:0] {
    PH_IDLE       = 5'b00001,
    PH_TRIG_LOW   = 5'b00010,
    PH_TRIG_HIGH  = 5'b00100,
    PH_PULSE_LOW  = 5'b01000,
    PH_PULSE_HIGH = 5'b10000
  } phase_t;

  // one input request
  typedef struct packed {
    logic              mode;
    logic [LevelW-1:0] sample;
  } alps_req_t;

  // one result
  typedef struct packed {
    logic line_level;
    logic led_on;
    logic sending;
    logic error_flag;
  } alps_res_t;

  // configuration registers
  typedef struct packed {
    logic [LevelW-1:0] max_level;
    logic [TicksW-1:0] trigger_low_ticks;
    logic [TicksW-1:0] half_bit_ticks;
    logic [TicksW-1:0] blink_period;
  } alps_cfg_t;

endpackage

/* design/averaged_level_pulse_count_sender.sv */
// top level: request register, sender state, result register and config registers
`timescale 1ns / 1ps

// channel   direction  payload      handshake
// req       in         alps_req_t   req_valid / req_stall
// res       out        alps_res_t   res_valid / res_stall
// cfg       in         index, data  cfg_write
//
// every request gives exactly one result, passing from the request register to the result register
// one request per cycle while the result is not stalled; the state update sits between the request register
// and the result register
// reset is synchronous; state and config registers return to their reset values
// a stalled result holds the request register, which then stalls the input

module averaged_level_pulse_count_sender (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  alps_pkg::alps_req_t                 req_data,
  output logic                                res_valid,
  input  logic                                res_stall,
  output alps_pkg::alps_res_t                 res_data,
  input  logic                                cfg_write,
  input  logic [alps_pkg::CfgIndexW-1:0]      cfg_index,
  input  logic [alps_pkg::CfgDataW-1:0]       cfg_data
);

  alps_pkg::alps_cfg_t cfg;
  alps_pkg::alps_req_t s1_data;
  alps_pkg::alps_res_t res_next;
  logic                s1_valid;
  logic                s1_advance;
  logic                req_take;

  // pipeline handshake
  assign s1_advance = s1_valid && (!res_valid || !res_stall);
  assign req_stall  = s1_valid && !s1_advance;
  assign req_take   = req_valid && !req_stall;

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= req_take || (s1_valid && !s1_advance);
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      s1_data <= req_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      res_data <= res_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_level         <= alps_pkg::MaxLevelRst;
      cfg.trigger_low_ticks <= alps_pkg::TriggerLowRst;
      cfg.half_bit_ticks    <= alps_pkg::HalfBitRst;
      cfg.blink_period      <= alps_pkg::BlinkPerRst;
    end else if (cfg_write) begin
      unique case (cfg_index)
        alps_pkg::RegMaxLevel: begin
          cfg.max_level <= cfg_data[alps_pkg::LevelW-1:0];
        end
        alps_pkg::RegTriggerLow: begin
          cfg.trigger_low_ticks <= cfg_data;
        end
        alps_pkg::RegHalfBit: begin
          cfg.half_bit_ticks <= cfg_data;
        end
        alps_pkg::RegBlinkPer: begin
          cfg.blink_period <= cfg_data;
        end
        default: begin
          cfg.max_level <= cfg.max_level;
        end
      endcase
    end
  end

  // sender state
  alps_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .step     (s1_advance),
    .req      (s1_data),
    .cfg      (cfg),
    .res_next (res_next)
  );

endmodule

/* design/alps_engine.sv */
// sender state and its per-request update
`timescale 1ns / 1ps

module alps_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  alps_pkg::alps_req_t req,
  input  alps_pkg::alps_cfg_t cfg,
  output alps_pkg::alps_res_t res_next
);

  logic [alps_pkg::SumW-1:0]   sample_sum, sample_sum_next;
  logic [alps_pkg::CountW-1:0] samples_taken, samples_taken_next;
  alps_pkg::phase_t            phase, phase_next;
  logic [alps_pkg::TicksW-1:0] phase_ticks, phase_ticks_next;
  logic [alps_pkg::LevelW-1:0] pulses_left, pulses_left_next;
  logic [alps_pkg::TicksW-1:0] blink_ticks, blink_ticks_next;
  logic                        line_reg, line_reg_next;
  logic                        led_reg, led_reg_next;
  logic                        error_reg, error_reg_next;

  logic [alps_pkg::SumW-1:0]   sum_add;
  logic [2*alps_pkg::SumW-1:0] avg_prod;
  logic [alps_pkg::AvgW-1:0]   avg;
  logic [alps_pkg::TicksW-1:0] blink_inc;
  logic [alps_pkg::TicksW-1:0] ticks_inc;

  // running sum and its average by reciprocal multiply
  assign sum_add  = sample_sum + alps_pkg::SumW'(req.sample);
  assign avg_prod = sum_add * alps_pkg::RecipMul;
  assign avg      = avg_prod[alps_pkg::RecipShift +: alps_pkg::AvgW];

  assign blink_inc = blink_ticks + 1'b1;
  assign ticks_inc = phase_ticks + 1'b1;

  // next state for one request
  always_comb begin
    sample_sum_next    = sample_sum;
    samples_taken_next = samples_taken;
    phase_next         = phase;
    phase_ticks_next   = phase_ticks;
    pulses_left_next   = pulses_left;
    blink_ticks_next   = blink_ticks;
    line_reg_next      = line_reg;
    led_reg_next       = led_reg;
    error_reg_next     = error_reg;

    if (req.mode == alps_pkg::ModeSample) begin
      // sample, taken only while idle
      if (phase == alps_pkg::PH_IDLE) begin
        led_reg_next = 1'b0;
        if (samples_taken == alps_pkg::CountW'(alps_pkg::SamplesAveraged - 1)) begin
          sample_sum_next    = '0;
          samples_taken_next = '0;
          if (avg == '0 || avg > alps_pkg::AvgW'(cfg.max_level)) begin
            line_reg_next  = 1'b0;
            led_reg_next   = 1'b1;
            error_reg_next = 1'b1;
          end else begin
            error_reg_next   = 1'b0;
            pulses_left_next = avg[alps_pkg::LevelW-1:0];
            phase_ticks_next = '0;
            line_reg_next    = 1'b0;
            phase_next       = alps_pkg::PH_TRIG_LOW;
          end
        end else begin
          sample_sum_next    = sum_add;
          samples_taken_next = samples_taken + 1'b1;
        end
      end
    end else if (phase != alps_pkg::PH_IDLE) begin
      // blink counter steps first
      if (blink_inc >= cfg.blink_period) begin
        blink_ticks_next = '0;
        led_reg_next     = ~led_reg;
      end else begin
        blink_ticks_next = blink_inc;
      end

      // phase timing
      phase_ticks_next = ticks_inc;
      unique case (phase)
        alps_pkg::PH_TRIG_LOW: begin
          if (ticks_inc >= cfg.trigger_low_ticks) begin
            phase_ticks_next = '0;
            line_reg_next    = 1'b1;
            phase_next       = alps_pkg::PH_TRIG_HIGH;
          end
        end
        alps_pkg::PH_PULSE_LOW: begin
          if (ticks_inc >= cfg.half_bit_ticks) begin
            phase_ticks_next = '0;
            line_reg_next    = 1'b1;
            phase_next       = alps_pkg::PH_PULSE_HIGH;
          end
        end
        alps_pkg::PH_TRIG_HIGH, alps_pkg::PH_PULSE_HIGH: begin
          if (ticks_inc >= cfg.half_bit_ticks) begin
            phase_ticks_next = '0;
            if (pulses_left != '0) begin
              pulses_left_next = pulses_left - 1'b1;
              line_reg_next    = 1'b0;
              phase_next       = alps_pkg::PH_PULSE_LOW;
            end else begin
              line_reg_next = 1'b1;
              led_reg_next  = 1'b0;
              phase_next    = alps_pkg::PH_IDLE;
            end
          end
        end
        default: begin
          phase_ticks_next = phase_ticks;
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum    <= '0;
      samples_taken <= '0;
      phase         <= alps_pkg::PH_IDLE;
      phase_ticks   <= '0;
      pulses_left   <= '0;
      blink_ticks   <= '0;
      line_reg      <= 1'b1;
      led_reg       <= 1'b0;
      error_reg     <= 1'b0;
    end else if (step) begin
      sample_sum    <= sample_sum_next;
      samples_taken <= samples_taken_next;
      phase         <= phase_next;
      phase_ticks   <= phase_ticks_next;
      pulses_left   <= pulses_left_next;
      blink_ticks   <= blink_ticks_next;
      line_reg      <= line_reg_next;
      led_reg       <= led_reg_next;
      error_reg     <= error_reg_next;
    end
  end

  // result shows the state after the update
  assign res_next.line_level = line_reg_next;
  assign res_next.led_on     = led_reg_next;
  assign res_next.sending    = (phase_next != alps_pkg::PH_IDLE);
  assign res_next.error_flag = error_reg_next;

endmodule

/* bench/tb_averaged_level_pulse_count_sender.sv */
// self-checking testbench for the averaged level pulse-count sender
`timescale 1ns / 1ps

module tb_averaged_level_pulse_count_sender;

  // cycles with no request or result taken before the run is abandoned
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned MaxReports = 50;

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           req_valid = 1'b0;
  logic                           req_stall;
  alps_pkg::alps_req_t            req_data  = '0;
  logic                           res_valid;
  logic                           res_stall = 1'b0;
  alps_pkg::alps_res_t            res_data;
  logic                           cfg_write = 1'b0;
  logic [alps_pkg::CfgIndexW-1:0] cfg_index = '0;
  logic [alps_pkg::CfgDataW-1:0]  cfg_data  = '0;

  averaged_level_pulse_count_sender u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predicted configuration
  logic [alps_pkg::LevelW-1:0] max_lvl   = alps_pkg::MaxLevelRst;
  logic [alps_pkg::TicksW-1:0] trig_len  = alps_pkg::TriggerLowRst;
  logic [alps_pkg::TicksW-1:0] half_len  = alps_pkg::HalfBitRst;
  logic [alps_pkg::TicksW-1:0] blink_per = alps_pkg::BlinkPerRst;

  // predicted sender state
  logic [alps_pkg::SumW-1:0]   level_sum   = '0;
  logic [alps_pkg::CountW-1:0] level_count = '0;
  alps_pkg::phase_t            tx_phase    = alps_pkg::PH_IDLE;
  logic [alps_pkg::TicksW-1:0] tx_ticks    = '0;
  logic [alps_pkg::LevelW-1:0] pulses_due  = '0;
  logic [alps_pkg::TicksW-1:0] blink_cnt   = '0;
  logic                        line_q      = 1'b1;
  logic                        led_q       = 1'b0;
  logic                        err_q       = 1'b0;

  alps_pkg::alps_res_t expected_line_state[$];
  alps_pkg::alps_res_t want;
  int unsigned fail_count    = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned counted_items = 0;
  bit          no_idle       = 1'b0;
  int unsigned calm_left     = 0;
  int unsigned res_calm      = 0;
  int unsigned stall_left    = 0;
  int unsigned stall_roll;

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // led blink step while sending
  function automatic void blink_step();
    blink_cnt = blink_cnt + 1'b1;
    if (blink_cnt >= blink_per) begin
      blink_cnt = '0;
      led_q     = ~led_q;
    end
  endfunction

  // one level sample while idle; the third one closes the average
  function automatic void add_level_sample(logic [alps_pkg::LevelW-1:0] value);
    logic [alps_pkg::SumW-1:0] avg;
    led_q       = 1'b0;
    level_sum   = level_sum + alps_pkg::SumW'(value);
    level_count = level_count + 1'b1;
    if (level_count < alps_pkg::CountW'(alps_pkg::SamplesAveraged)) return;
    avg         = level_sum / alps_pkg::SumW'(alps_pkg::SamplesAveraged);
    level_sum   = '0;
    level_count = '0;
    if (avg == 0 || avg > max_lvl) begin
      line_q   = 1'b0;
      led_q    = 1'b1;
      err_q    = 1'b1;
      tx_phase = alps_pkg::PH_IDLE;
    end else begin
      err_q      = 1'b0;
      pulses_due = avg[alps_pkg::LevelW-1:0];
      tx_ticks   = '0;
      line_q     = 1'b0;
      tx_phase   = alps_pkg::PH_TRIG_LOW;
    end
  endfunction

  // one clock tick: blink first, then the phase counter
  function automatic void step_tick();
    if (tx_phase == alps_pkg::PH_IDLE) return;
    blink_step();
    tx_ticks = tx_ticks + 1'b1;
    case (tx_phase)
      alps_pkg::PH_TRIG_LOW: begin
        if (tx_ticks >= trig_len) begin
          tx_ticks = '0;
          line_q   = 1'b1;
          tx_phase = alps_pkg::PH_TRIG_HIGH;
        end
      end
      alps_pkg::PH_PULSE_LOW: begin
        if (tx_ticks >= half_len) begin
          tx_ticks = '0;
          line_q   = 1'b1;
          tx_phase = alps_pkg::PH_PULSE_HIGH;
        end
      end
      default: begin
        if (tx_ticks >= half_len) begin
          tx_ticks = '0;
          if (pulses_due != 0) begin
            pulses_due = pulses_due - 1'b1;
            line_q     = 1'b0;
            tx_phase   = alps_pkg::PH_PULSE_LOW;
          end else begin
            line_q   = 1'b1;
            led_q    = 1'b0;
            tx_phase = alps_pkg::PH_IDLE;
          end
        end
      end
    endcase
  endfunction

  // output levels after one request
  function automatic alps_pkg::alps_res_t predict_line_state(alps_pkg::alps_req_t r);
    alps_pkg::alps_res_t o;
    if (r.mode == alps_pkg::ModeSample) begin
      if (tx_phase == alps_pkg::PH_IDLE) add_level_sample(r.sample);
    end else begin
      step_tick();
    end
    o.line_level = line_q;
    o.led_on     = led_q;
    o.sending    = (tx_phase != alps_pkg::PH_IDLE);
    o.error_flag = err_q;
    return o;
  endfunction

  // sender gap: mostly none, some short, a few long, calm stretches now and then
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (no_idle) return 0;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    roll = $urandom_range(99, 0);
    if (roll < 2) begin
      calm_left = $urandom_range(150, 30);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // send one request and record its expected result once taken
  task automatic send_req(input logic mode, input logic [alps_pkg::LevelW-1:0] value);
    alps_pkg::alps_req_t r;
    int unsigned         gap;
    r.mode   = mode;
    r.sample = value;
    gap      = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    // ignored samples and idle ticks are not counted
    if (mode == alps_pkg::ModeSample ? tx_phase == alps_pkg::PH_IDLE
                                     : tx_phase != alps_pkg::PH_IDLE) counted_items++;
    expected_line_state.push_back(predict_line_state(r));
  endtask

  // hold off the sender until every expected result has come
  task automatic drain_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (expected_line_state.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [alps_pkg::CfgIndexW-1:0] idx,
                           input logic [alps_pkg::CfgDataW-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      alps_pkg::RegMaxLevel:   max_lvl   = value[alps_pkg::LevelW-1:0];
      alps_pkg::RegTriggerLow: trig_len  = value;
      alps_pkg::RegHalfBit:    half_len  = value;
      alps_pkg::RegBlinkPer:   blink_per = value;
      default: ;
    endcase
  endtask

  // all four registers once no results are outstanding; upper bits of the level register carry noise
  task automatic set_config(input logic [alps_pkg::LevelW-1:0] lvl,
                            input logic [alps_pkg::TicksW-1:0] trig,
                            input logic [alps_pkg::TicksW-1:0] half,
                            input logic [alps_pkg::TicksW-1:0] blink);
    drain_results();
    write_reg(alps_pkg::RegMaxLevel, {8'($urandom), lvl});
    write_reg(alps_pkg::RegTriggerLow, trig);
    write_reg(alps_pkg::RegHalfBit, half);
    write_reg(alps_pkg::RegBlinkPer, blink);
  endtask

  // three samples with the given sum, split at random
  task automatic send_average(input int unsigned total);
    int unsigned first;
    int unsigned rest;
    int unsigned second;
    first  = $urandom_range(total > 255 ? 255 : total, total > 510 ? total - 510 : 0);
    rest   = total - first;
    second = $urandom_range(rest > 255 ? 255 : rest, rest > 255 ? rest - 255 : 0);
    send_req(alps_pkg::ModeSample, alps_pkg::LevelW'(first));
    send_req(alps_pkg::ModeSample, alps_pkg::LevelW'(second));
    send_req(alps_pkg::ModeSample, alps_pkg::LevelW'(rest - second));
  endtask

  // tick until the transmission is over, with some ignored samples mixed in
  task automatic finish_tx();
    while (tx_phase != alps_pkg::PH_IDLE) begin
      if ($urandom_range(19, 0) == 0) send_req(alps_pkg::ModeSample, 8'($urandom));
      else send_req(alps_pkg::ModeTick, 8'($urandom));
    end
  endtask

  // reset settings: idle tick, zero average, average over the limit, one short pulse
  task automatic test_reset_defaults();
    send_req(alps_pkg::ModeTick, 8'h00);
    send_average(0);
    send_req(alps_pkg::ModeSample, 8'hFF);
    send_req(alps_pkg::ModeSample, 8'hFF);
    send_req(alps_pkg::ModeSample, 8'hFF);
    send_average(4);
    finish_tx();
  endtask

  // limits of the averaged level and the error path
  task automatic test_error_cases();
    set_config(8'd1, 16'd1, 16'd1, 16'd1);
    send_average(6);
    send_average(3);
    finish_tx();
    send_average(2);
    set_config(8'd0, 16'd1, 16'd1, 16'd1);
    send_average(3);
    set_config(8'd255, 16'd1, 16'd1, 16'd3);
    send_average(765);
    finish_tx();
  endtask

  // zero lengths behave as one tick
  task automatic test_zero_lengths();
    set_config(alps_pkg::MaxLevelRst, 16'd0, 16'd0, 16'd0);
    send_average(9);
    finish_tx();
  endtask

  // largest trigger, half bit and blink period, each cut short by a later write
  task automatic test_long_lengths();
    set_config(8'd2, 16'hFFFF, 16'd1, 16'hFFFF);
    no_idle = 1'b1;
    send_average(3);
    repeat (100) send_req(alps_pkg::ModeTick, 8'($urandom));
    no_idle = 1'b0;
    set_config(8'd2, 16'd1, 16'd1, 16'd4);
    finish_tx();
    set_config(8'd2, 16'd1, 16'hFFFF, 16'hFFFF);
    send_average(6);
    repeat (100) send_req(alps_pkg::ModeTick, 8'($urandom));
    set_config(8'd2, 16'd1, 16'd2, 16'd5);
    finish_tx();
  endtask

  // mostly whole transmissions with random content, plus noise and pauses
  task automatic run_random(input int unsigned n);
    int unsigned target;
    int unsigned roll;
    int unsigned kind;
    int unsigned avg;
    target = counted_items + n;
    while (counted_items < target) begin
      roll = $urandom_range(99, 0);
      if (roll < 75) begin
        // close any partial average left by noise first
        finish_tx();
        while (level_count != 0) send_req(alps_pkg::ModeSample, 8'($urandom));
        finish_tx();
        kind = $urandom_range(99, 0);
        if (kind < 80) begin
          avg = $urandom_range(max_lvl < 12 ? max_lvl : 12, 1);
          send_average(3 * avg + $urandom_range(2, 0));
        end else if (kind < 83) begin
          avg = $urandom_range(max_lvl, 1);
          send_average(3 * avg + (avg == 255 ? 0 : $urandom_range(2, 0)));
        end else if (kind < 91 || max_lvl == 8'd255) begin
          send_average($urandom_range(2, 0));
        end else begin
          avg = $urandom_range(255, max_lvl + 1);
          send_average(3 * avg + (avg == 255 ? 0 : $urandom_range(2, 0)));
        end
        finish_tx();
      end else if (roll < 97) begin
        repeat ($urandom_range(3, 1)) send_req(1'($urandom), 8'($urandom));
      end else begin
        drain_results();
      end
    end
  endtask

  task automatic test_random();
    set_config(8'd255, 16'($urandom_range(6, 1)), 16'($urandom_range(3, 1)),
               16'($urandom_range(40, 1)));
    run_random(120);
    set_config(8'($urandom_range(20, 1)), 16'($urandom_range(3, 1)),
               16'($urandom_range(2, 1)), 16'($urandom_range(40, 2)));
    run_random(120);
    set_config(8'($urandom_range(254, 21)), 16'($urandom_range(6, 1)),
               16'($urandom_range(3, 1)), 16'($urandom_range(40, 1)));
    run_random(120);
    set_config(8'd1, 16'($urandom_range(4, 1)), 16'($urandom_range(3, 1)),
               16'($urandom_range(10, 1)));
    run_random(120);
  endtask

  // receiver stall: mostly none, short or long bursts, calm stretches
  always @(negedge clk) begin
    if (no_idle || res_calm > 0) begin
      stall_left = 0;
      if (res_calm > 0) res_calm--;
    end else if (stall_left == 0) begin
      stall_roll = $urandom_range(999, 0);
      if (stall_roll < 10) res_calm = $urandom_range(200, 50);
      else if (stall_roll < 650) stall_left = 0;
      else if (stall_roll < 960) stall_left = $urandom_range(3, 1);
      else stall_left = $urandom_range(40, 8);
    end
    res_stall <= (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  function automatic void check_field(string name, logic want_bit, logic got_bit);
    if (got_bit !== want_bit) begin
      if (fail_count < MaxReports)
        $display("%0t: %s mismatch: expected %b actual %b", $time, name, want_bit, got_bit);
      fail_count++;
    end
  endfunction

  // compare each taken result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (expected_line_state.size() == 0) begin
        if (fail_count < MaxReports)
          $display("%0t: unexpected result: expected none actual %b", $time, res_data);
        fail_count++;
      end else begin
        want = expected_line_state.pop_front();
        check_field("line_level", want.line_level, res_data.line_level);
        check_field("led_on", want.led_on, res_data.led_on);
        check_field("sending", want.sending, res_data.sending);
        check_field("error_flag", want.error_flag, res_data.error_flag);
      end
    end
  end

  // watchdog on cycles where nothing moves
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_error_cases();
    test_zero_lengths();
    test_long_lengths();
    test_random();
    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
